[hw/rtl/spm_pkg.sv]
// Package of the stable priority mailbox: command and status codes,
// fixed field widths and default sizes. No dependencies.
`default_nettype none

package spm_pkg;

  localparam int CmdBits    = 3;
  localparam int RankBits   = 5;
  localparam int CountBits  = 6;
  localparam int StatusBits = 2;

  localparam int DefDepth      = 32;
  localparam int DefPrioBits   = 8;
  localparam int DefSenderBits = 8;
  localparam int DefHandleBits = 16;

  typedef enum logic [CmdBits-1:0] {
    CMD_INSERT           = 3'd0,
    CMD_TAKE_HEAD        = 3'd1,
    CMD_TAKE_FIRST_FROM  = 3'd2,
    CMD_COUNT_FROM       = 3'd3,
    CMD_TAKE_RANKED_FROM = 3'd4,
    CMD_TAKE_RANKED      = 3'd5
  } spm_cmd_e;

  typedef enum logic [StatusBits-1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } spm_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } spm_state_e;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic do_insert;
    logic do_remove;
    logic filt;
  } spm_cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/spm_req_if.sv]
// Request channel of the stable priority mailbox: valid/ready plus command
// payload. Depends on spm_pkg.
`default_nettype none

interface spm_req_if
  import spm_pkg::*;
#(
  parameter int PRIO_BITS   = DefPrioBits,
  parameter int SENDER_BITS = DefSenderBits,
  parameter int HANDLE_BITS = DefHandleBits
);
  logic                   valid;
  logic                   ready;
  logic [CmdBits-1:0]     cmd;
  logic [HANDLE_BITS-1:0] msg_handle;
  logic [PRIO_BITS-1:0]   msg_priority;
  logic [SENDER_BITS-1:0] sender_id;
  logic [RankBits-1:0]    pick_rank;

  modport source (
    output valid, cmd, msg_handle, msg_priority, sender_id, pick_rank,
    input  ready
  );

  modport sink (
    input  valid, cmd, msg_handle, msg_priority, sender_id, pick_rank,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/spm_rsp_if.sv]
// Response channel of the stable priority mailbox: valid/ready plus result
// payload. Depends on spm_pkg.
`default_nettype none

interface spm_rsp_if
  import spm_pkg::*;
#(
  parameter int PRIO_BITS   = DefPrioBits,
  parameter int SENDER_BITS = DefSenderBits,
  parameter int HANDLE_BITS = DefHandleBits
);
  logic                   valid;
  logic                   ready;
  spm_status_e            status;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [PRIO_BITS-1:0]   out_priority;
  logic [SENDER_BITS-1:0] out_sender;
  logic [CountBits-1:0]   match_count;

  modport source (
    output valid, status, out_handle, out_priority, out_sender, match_count,
    input  ready
  );

  modport sink (
    input  valid, status, out_handle, out_priority, out_sender, match_count,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/spm_cell.sv]
// One slot of the mailbox chain: holds an entry and a running match count,
// shifts with its neighbors on insert and remove. Depends on spm_pkg.
`default_nettype none

module spm_cell
  import spm_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int DEPTH       = DefDepth,
  parameter int PRIO_BITS   = DefPrioBits,
  parameter int SENDER_BITS = DefSenderBits,
  parameter int HANDLE_BITS = DefHandleBits,
  localparam int CntBits    = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk_i,
  input  wire spm_cell_ctrl_t         ctrl_i,
  input  wire logic [CntBits-1:0]     occ_i,
  input  wire logic [HANDLE_BITS-1:0] new_handle_i,
  input  wire logic [PRIO_BITS-1:0]   new_prio_i,
  input  wire logic [SENDER_BITS-1:0] new_sender_i,
  input  wire logic [RankBits-1:0]    rank_i,
  input  wire logic [HANDLE_BITS-1:0] prev_handle_i,
  input  wire logic [PRIO_BITS-1:0]   prev_prio_i,
  input  wire logic [SENDER_BITS-1:0] prev_sender_i,
  input  wire logic                   prev_shift_i,
  input  wire logic                   prev_rem_i,
  input  wire logic [CntBits-1:0]     prev_cnt_i,
  input  wire logic [HANDLE_BITS-1:0] next_handle_i,
  input  wire logic [PRIO_BITS-1:0]   next_prio_i,
  input  wire logic [SENDER_BITS-1:0] next_sender_i,
  output logic [HANDLE_BITS-1:0]      handle_o,
  output logic [PRIO_BITS-1:0]        prio_o,
  output logic [SENDER_BITS-1:0]      sender_o,
  output logic                        shift_o,
  output logic                        rem_o,
  output logic                        pick_o,
  output logic [CntBits-1:0]          cnt_o
);

  localparam int CmpBits = (CntBits > RankBits) ? CntBits : RankBits;

  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic [PRIO_BITS-1:0]   prio_q, prio_d;
  logic [SENDER_BITS-1:0] sender_q, sender_d;
  logic [CntBits-1:0]     cnt_q, cnt_d;
  logic                   valid;
  logic                   match;

  assign valid   = CntBits'(IDX) < occ_i;
  assign match   = valid && (!ctrl_i.filt || (sender_q == new_sender_i));
  // Occupied slots are sorted, so this flag is low up to the insert point.
  assign shift_o = !valid || (new_prio_i > prio_q);
  // Matches seen through this slot exceed the rank: at or behind the target.
  assign rem_o   = CmpBits'(cnt_q) > CmpBits'(rank_i);
  assign pick_o  = rem_o && !prev_rem_i;

  assign handle_o = handle_q;
  assign prio_o   = prio_q;
  assign sender_o = sender_q;
  assign cnt_o    = cnt_q;

  always_comb begin
    handle_d = handle_q;
    prio_d   = prio_q;
    sender_d = sender_q;
    cnt_d    = prev_cnt_i + CntBits'(match);
    priority if (ctrl_i.do_insert && shift_o && prev_shift_i) begin
      handle_d = prev_handle_i;
      prio_d   = prev_prio_i;
      sender_d = prev_sender_i;
    end else if (ctrl_i.do_insert && shift_o) begin
      handle_d = new_handle_i;
      prio_d   = new_prio_i;
      sender_d = new_sender_i;
    end else if (ctrl_i.do_remove && rem_o) begin
      handle_d = next_handle_i;
      prio_d   = next_prio_i;
      sender_d = next_sender_i;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    prio_q   <= prio_d;
    sender_q <= sender_d;
    cnt_q    <= cnt_d;
  end

endmodule

`default_nettype wire

[hw/rtl/stable_priority_mailbox.sv]
// Top level of the stable priority mailbox: command sequencer, chain of
// spm_cell slots and response register. Depends on spm_pkg, spm_req_if,
// spm_rsp_if and spm_cell.
`default_nettype none

// Ordered mailbox kept highest priority first, first in first out among
// equal priorities, one request per command and one response each. Insert
// and the unused command codes go from acceptance straight to the finish
// state; take and count commands first pass through the scan state, which
// waits while the match count ripples one slot per cycle through DEPTH cells.
// A finished response waits in an output register, so the next request is
// accepted while it is pending; a command stalls only in its finish state if
// the previous response has not been taken.
module stable_priority_mailbox
  import spm_pkg::*;
#(
  parameter int DEPTH       = DefDepth,
  parameter int PRIO_BITS   = DefPrioBits,
  parameter int SENDER_BITS = DefSenderBits,
  parameter int HANDLE_BITS = DefHandleBits
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spm_req_if.sink    req_i,
  spm_rsp_if.source  rsp_o
);

  localparam int CntBits  = $clog2(DEPTH + 1);
  localparam int ScanBits = $clog2(DEPTH);
  localparam int CmpBits  = (CntBits > RankBits) ? CntBits : RankBits;

  spm_state_e             state_q, state_d;
  logic [ScanBits-1:0]    scan_q, scan_d;
  logic [CntBits-1:0]     occ_q, occ_d;
  logic [CmdBits-1:0]     cmd_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [PRIO_BITS-1:0]   prio_q;
  logic [SENDER_BITS-1:0] sender_q;
  logic [RankBits-1:0]    rank_q;
  logic                   filt_q;
  logic                   load_cmd;

  logic                   rsp_valid_q, rsp_valid_d;
  spm_status_e            status_q, status_d;
  logic [HANDLE_BITS-1:0] out_handle_q, out_handle_d;
  logic [PRIO_BITS-1:0]   out_prio_q, out_prio_d;
  logic [SENDER_BITS-1:0] out_sender_q, out_sender_d;
  logic [CountBits-1:0]   count_q, count_d;
  logic                   slot_free;

  spm_cell_ctrl_t         ctrl;

  logic [HANDLE_BITS-1:0] c_handle [DEPTH];
  logic [PRIO_BITS-1:0]   c_prio   [DEPTH];
  logic [SENDER_BITS-1:0] c_sender [DEPTH];
  logic [CntBits-1:0]     c_cnt    [DEPTH];
  logic [DEPTH-1:0]       c_shift;
  logic [DEPTH-1:0]       c_rem;
  logic [DEPTH-1:0]       pick;

  logic [HANDLE_BITS-1:0] sel_handle;
  logic [PRIO_BITS-1:0]   sel_prio;
  logic [SENDER_BITS-1:0] sel_sender;
  logic                   found;

  // ---------------------------------------------------------------------
  // Chain of cells
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] prev_handle, next_handle;
    logic [PRIO_BITS-1:0]   prev_prio, next_prio;
    logic [SENDER_BITS-1:0] prev_sender, next_sender;
    logic                   prev_shift, prev_rem;
    logic [CntBits-1:0]     prev_cnt;

    if (i == 0) begin : g_head
      assign prev_handle = handle_q;
      assign prev_prio   = prio_q;
      assign prev_sender = sender_q;
      assign prev_shift  = 1'b0;
      assign prev_rem    = 1'b0;
      assign prev_cnt    = '0;
    end else begin : g_body
      assign prev_handle = c_handle[i-1];
      assign prev_prio   = c_prio[i-1];
      assign prev_sender = c_sender[i-1];
      assign prev_shift  = c_shift[i-1];
      assign prev_rem    = c_rem[i-1];
      assign prev_cnt    = c_cnt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_handle = '0;
      assign next_prio   = '0;
      assign next_sender = '0;
    end else begin : g_link
      assign next_handle = c_handle[i+1];
      assign next_prio   = c_prio[i+1];
      assign next_sender = c_sender[i+1];
    end

    spm_cell #(
      .IDX        (i),
      .DEPTH      (DEPTH),
      .PRIO_BITS  (PRIO_BITS),
      .SENDER_BITS(SENDER_BITS),
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ_q),
      .new_handle_i (handle_q),
      .new_prio_i   (prio_q),
      .new_sender_i (sender_q),
      .rank_i       (rank_q),
      .prev_handle_i(prev_handle),
      .prev_prio_i  (prev_prio),
      .prev_sender_i(prev_sender),
      .prev_shift_i (prev_shift),
      .prev_rem_i   (prev_rem),
      .prev_cnt_i   (prev_cnt),
      .next_handle_i(next_handle),
      .next_prio_i  (next_prio),
      .next_sender_i(next_sender),
      .handle_o     (c_handle[i]),
      .prio_o       (c_prio[i]),
      .sender_o     (c_sender[i]),
      .shift_o      (c_shift[i]),
      .rem_o        (c_rem[i]),
      .pick_o       (pick[i]),
      .cnt_o        (c_cnt[i])
    );
  end

  // Pull out the target entry; at most one cell is picked.
  always_comb begin
    sel_handle = '0;
    sel_prio   = '0;
    sel_sender = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_handle = sel_handle | (c_handle[i] & {HANDLE_BITS{pick[i]}});
      sel_prio   = sel_prio   | (c_prio[i]   & {PRIO_BITS{pick[i]}});
      sel_sender = sel_sender | (c_sender[i] & {SENDER_BITS{pick[i]}});
    end
  end

  assign found = CmpBits'(c_cnt[DEPTH-1]) > CmpBits'(rank_q);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    occ_d        = occ_q;
    load_cmd     = 1'b0;
    ctrl         = '0;
    ctrl.filt    = filt_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    status_d     = status_q;
    out_handle_d = out_handle_q;
    out_prio_d   = out_prio_q;
    out_sender_d = out_sender_q;
    count_d      = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          load_cmd = 1'b1;
          scan_d   = '0;
          if ((req_i.cmd == CMD_INSERT) || (req_i.cmd > CMD_TAKE_RANKED)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Let the match count settle through all cells.
        scan_d = scan_q + 1'b1;
        if (scan_q == ScanBits'(DEPTH - 1)) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (slot_free) begin
          state_d      = ST_IDLE;
          rsp_valid_d  = 1'b1;
          status_d     = STAT_NONE;
          out_handle_d = '0;
          out_prio_d   = '0;
          out_sender_d = '0;
          count_d      = CountBits'(occ_q);
          unique case (cmd_q)
            CMD_INSERT: begin
              if (occ_q == CntBits'(DEPTH)) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.do_insert = 1'b1;
                occ_d          = occ_q + 1'b1;
                status_d       = STAT_OK;
                count_d        = CountBits'(occ_q + 1'b1);
              end
            end
            CMD_COUNT_FROM: begin
              status_d = STAT_OK;
              count_d  = CountBits'(c_cnt[DEPTH-1]);
            end
            CMD_TAKE_HEAD, CMD_TAKE_FIRST_FROM, CMD_TAKE_RANKED_FROM,
            CMD_TAKE_RANKED: begin
              if (found) begin
                ctrl.do_remove = 1'b1;
                occ_d          = occ_q - 1'b1;
                status_d       = STAT_OK;
                out_handle_d   = sel_handle;
                out_prio_d     = sel_prio;
                out_sender_d   = sel_sender;
                count_d        = CountBits'(occ_q - 1'b1);
              end
            end
            default: begin
              status_d = STAT_NONE;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      occ_q       <= occ_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Hold the command for the whole operation.
  always_ff @(posedge clk_i) begin
    if (load_cmd) begin
      cmd_q    <= req_i.cmd;
      handle_q <= req_i.msg_handle;
      prio_q   <= req_i.msg_priority;
      sender_q <= req_i.sender_id;
      filt_q   <= (req_i.cmd == CMD_TAKE_FIRST_FROM) ||
                  (req_i.cmd == CMD_COUNT_FROM) ||
                  (req_i.cmd == CMD_TAKE_RANKED_FROM);
      rank_q   <= ((req_i.cmd == CMD_TAKE_RANKED_FROM) ||
                   (req_i.cmd == CMD_TAKE_RANKED)) ? req_i.pick_rank : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    out_handle_q <= out_handle_d;
    out_prio_q   <= out_prio_d;
    out_sender_q <= out_sender_d;
    count_q      <= count_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_handle   = out_handle_q;
  assign rsp_o.out_priority = out_prio_q;
  assign rsp_o.out_sender   = out_sender_q;
  assign rsp_o.match_count  = count_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntBits'(DEPTH))
    else $error("occupancy above depth");

  // The count chain is only settled after a full scan, so check on removal.
  a_single_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.do_remove |-> $onehot0(pick))
    else $error("more than one slot picked for removal");

  a_remove_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.do_remove |=> (occ_q == $past(occ_q) - 1'b1))
    else $error("removal did not lower occupancy by one");

  a_insert_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.do_insert |=> (occ_q == $past(occ_q) + 1'b1))
    else $error("insert did not raise occupancy by one");
`endif

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench of stable_priority_mailbox: drives commands over the
// request channel, predicts every response and checks it field by field.
// Depends on spm_pkg, spm_req_if, spm_rsp_if and the mailbox RTL.
`timescale 1ns / 1ps

module testbench;
  import spm_pkg::*;

  localparam int Depth      = DefDepth;
  localparam int PrioBits   = DefPrioBits;
  localparam int SenderBits = DefSenderBits;
  localparam int HandleBits = DefHandleBits;
  localparam int HoldCycles = 400;

  // Command codes outside the defined set; the block must ignore them.
  localparam logic [CmdBits-1:0] CmdSpare6 = 3'd6;
  localparam logic [CmdBits-1:0] CmdSpare7 = 3'd7;

  typedef logic [HandleBits-1:0] handle_t;
  typedef logic [PrioBits-1:0]   prio_t;
  typedef logic [SenderBits-1:0] sender_t;
  typedef logic [RankBits-1:0]   rank_t;

  typedef struct packed {
    handle_t handle;
    prio_t   prio;
    sender_t sender;
  } mbox_entry_t;

  typedef struct packed {
    spm_status_e          status;
    handle_t              handle;
    prio_t                prio;
    sender_t              sender;
    logic [CountBits-1:0] count;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  spm_req_if #(
    .PRIO_BITS  (PrioBits),
    .SENDER_BITS(SenderBits),
    .HANDLE_BITS(HandleBits)
  ) req_if ();
  spm_rsp_if #(
    .PRIO_BITS  (PrioBits),
    .SENDER_BITS(SenderBits),
    .HANDLE_BITS(HandleBits)
  ) rsp_if ();

  stable_priority_mailbox #(
    .DEPTH      (Depth),
    .PRIO_BITS  (PrioBits),
    .SENDER_BITS(SenderBits),
    .HANDLE_BITS(HandleBits)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Mailbox contents as the predictor sees them, head first.
  mbox_entry_t mbox_slots[Depth];
  int          mbox_count;
  reply_t      pending_replies[$];
  int          error_count;
  bit          idle_enable;
  bit          hold_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Position of the rank-th entry, or of the rank-th entry from snd; -1 if none.
  function automatic int find_position(input bit filtered, input sender_t snd,
                                       input rank_t rank);
    int seen;
    int pos;
    seen = 0;
    pos  = -1;
    for (int i = 0; i < mbox_count; i++) begin
      if (pos < 0 && (!filtered || mbox_slots[i].sender == snd)) begin
        if (seen == int'(rank)) pos = i;
        seen++;
      end
    end
    return pos;
  endfunction

  function automatic reply_t predict_mailbox_reply(input logic [CmdBits-1:0] op,
      input handle_t h, input prio_t p, input sender_t s, input rank_t rank);
    reply_t      r;
    mbox_entry_t taken;
    int          pos;
    int          ins;
    int          match_total;
    r        = '0;
    r.status = STAT_NONE;
    pos      = -1;
    case (op)
      CMD_INSERT: begin
        if (mbox_count >= Depth) begin
          r.status = STAT_FULL;
        end else begin
          // Place behind every entry of equal or higher priority.
          ins = mbox_count;
          for (int i = 0; i < mbox_count; i++)
            if (ins == mbox_count && p > mbox_slots[i].prio) ins = i;
          for (int i = mbox_count; i > ins; i--) mbox_slots[i] = mbox_slots[i-1];
          mbox_slots[ins] = '{handle: h, prio: p, sender: s};
          mbox_count++;
          r.status = STAT_OK;
        end
      end
      CMD_TAKE_HEAD:        pos = find_position(1'b0, s, '0);
      CMD_TAKE_FIRST_FROM:  pos = find_position(1'b1, s, '0);
      CMD_TAKE_RANKED_FROM: pos = find_position(1'b1, s, rank);
      CMD_TAKE_RANKED:      pos = find_position(1'b0, s, rank);
      default: ;
    endcase
    if (pos >= 0) begin
      taken = mbox_slots[pos];
      for (int i = pos; i + 1 < mbox_count; i++) mbox_slots[i] = mbox_slots[i+1];
      mbox_count--;
      r.status = STAT_OK;
      r.handle = taken.handle;
      r.prio   = taken.prio;
      r.sender = taken.sender;
    end
    r.count = mbox_count[CountBits-1:0];
    if (op == CMD_COUNT_FROM) begin
      match_total = 0;
      for (int i = 0; i < mbox_count; i++)
        if (mbox_slots[i].sender == s) match_total++;
      r.count  = match_total[CountBits-1:0];
      r.status = STAT_OK;
    end
    return r;
  endfunction

  task automatic send_request(input logic [CmdBits-1:0] op, input handle_t handle,
      input prio_t prio, input sender_t sender, input rank_t rank);
    int gap;
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      req_if.valid        = 1'b0;
      req_if.cmd          = CmdBits'($urandom);
      req_if.msg_handle   = handle_t'($urandom);
      req_if.msg_priority = prio_t'($urandom);
      req_if.sender_id    = sender_t'($urandom);
      req_if.pick_rank    = rank_t'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        = 1'b1;
    req_if.cmd          = op;
    req_if.msg_handle   = handle;
    req_if.msg_priority = prio;
    req_if.sender_id    = sender;
    req_if.pick_rank    = rank;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_replies = {pending_replies,
                       predict_mailbox_reply(op, handle, prio, sender, rank)};
  endtask

  function automatic prio_t random_prio();
    // Favor a few levels so that ties are common.
    if ($urandom_range(0, 9) < 6) return prio_t'($urandom_range(0, 3) * 85);
    return prio_t'($urandom);
  endfunction

  function automatic sender_t random_sender();
    if ($urandom_range(0, 99) < 85) return sender_t'($urandom_range(0, 5));
    return sender_t'($urandom);
  endfunction

  task automatic send_random_request();
    logic [CmdBits-1:0] op;
    int                 roll;
    int                 insert_pct;
    rank_t              rank;
    insert_pct = (mbox_count < 8) ? 70 : (mbox_count > 28) ? 30 : 50;
    roll = $urandom_range(0, 99);
    if (roll < 2)               op = (roll == 0) ? CmdSpare6 : CmdSpare7;
    else if (roll < insert_pct) op = CMD_INSERT;
    else op = CmdBits'($urandom_range(CMD_TAKE_HEAD, CMD_TAKE_RANKED));
    if ($urandom_range(0, 9) < 8) rank = rank_t'($urandom_range(0, 3));
    else                          rank = rank_t'($urandom);
    send_request(op, handle_t'($urandom), random_prio(), random_sender(), rank);
  endtask

  task automatic test_empty_commands();
    send_request(CMD_TAKE_HEAD, 16'h1234, 8'h12, 8'h00, 5'd0);
    send_request(CMD_TAKE_FIRST_FROM, '0, '0, 8'h07, 5'd0);
    send_request(CMD_COUNT_FROM, '0, '0, 8'hFF, 5'd0);
    send_request(CMD_TAKE_RANKED_FROM, '0, '0, 8'h01, 5'd31);
    send_request(CMD_TAKE_RANKED, '0, '0, 8'h00, 5'd0);
    send_request(CmdSpare6, 16'hFFFF, 8'hFF, 8'hFF, 5'd31);
  endtask

  task automatic test_ordering();
    send_request(CMD_INSERT, 16'h0001, 8'h80, 8'h03, 5'd0);
    send_request(CMD_INSERT, 16'h0002, 8'h80, 8'h03, 5'd0);
    send_request(CMD_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 5'd31);
    send_request(CMD_INSERT, 16'h0000, 8'h00, 8'h00, 5'd0);
    send_request(CMD_INSERT, 16'h0003, 8'h80, 8'h05, 5'd0);
    send_request(CMD_COUNT_FROM, '0, '0, 8'h03, 5'd0);
    send_request(CMD_TAKE_RANKED_FROM, '0, '0, 8'h03, 5'd1);
    send_request(CMD_TAKE_RANKED, '0, '0, 8'h00, 5'd31);
    send_request(CMD_TAKE_FIRST_FROM, '0, '0, 8'hFF, 5'd0);
    send_request(CMD_TAKE_RANKED_FROM, '0, '0, 8'h09, 5'd0);
    send_request(CMD_TAKE_RANKED, '0, '0, 8'h00, 5'd1);
    send_request(CMD_TAKE_HEAD, '0, '0, 8'h00, 5'd0);
    send_request(CmdSpare7, 16'h5A5A, 8'h01, 8'h02, 5'd3);
    send_request(CMD_INSERT, 16'hA5A5, 8'h7F, 8'h80, 5'd0);
    send_request(CMD_TAKE_FIRST_FROM, '0, '0, 8'h00, 5'd0);
    send_request(CMD_TAKE_HEAD, '0, '0, 8'h00, 5'd0);
    send_request(CMD_TAKE_HEAD, '0, '0, 8'h00, 5'd0);
  endtask

  task automatic test_full_store();
    while (mbox_count < Depth)
      send_request(CMD_INSERT, handle_t'($urandom), random_prio(), random_sender(), '0);
    send_request(CMD_INSERT, handle_t'($urandom), 8'hFF, 8'h01, 5'd0);
    send_request(CMD_INSERT, handle_t'($urandom), 8'h00, 8'h02, 5'd0);
    send_request(CMD_COUNT_FROM, '0, '0, sender_t'($urandom_range(0, 5)), 5'd0);
    // Rank 31 reaches the tail of a full store.
    send_request(CMD_TAKE_RANKED, '0, '0, 8'h00, 5'd31);
    while (mbox_count > 0) begin
      if ($urandom_range(0, 1))
        send_request(CMD_TAKE_HEAD, '0, '0, '0, '0);
      else
        send_request(CMD_TAKE_RANKED_FROM, '0, '0, sender_t'($urandom_range(0, 5)),
                     rank_t'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_receiver_hold();
    hold_request = 1'b1;
    repeat (40) send_random_request();
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      // Switch idling per stretch so that some stretches run back to back.
      if (i % 40 == 0) idle_enable = ($urandom_range(0, 3) != 0);
      send_random_request();
    end
  endtask

  task automatic test_steady_tail(input int count);
    idle_enable = 1'b0;
    repeat (count) send_random_request();
  endtask

  // Response side: random stall bursts plus one long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (!rst_ni) begin
        rsp_if.ready = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready = 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(1, 16) - 1;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status = rsp_if.status;
      got.handle = rsp_if.out_handle;
      got.prio   = rsp_if.out_priority;
      got.sender = rsp_if.out_sender;
      got.count  = rsp_if.match_count;
      if (pending_replies.size() == 0) begin
        error_count++;
        $display("%0t: response with no request pending:", $time,
                 " status=%0d handle=%h prio=%h sender=%h count=%0d",
                 got.status, got.handle, got.prio, got.sender, got.count);
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        if (got !== want) begin
          error_count++;
          $display("%0t: mismatch expected", $time,
                   " status=%0d handle=%h prio=%h sender=%h count=%0d",
                   want.status, want.handle, want.prio, want.sender, want.count);
          $display("%0t: mismatch actual  ", $time,
                   " status=%0d handle=%h prio=%h sender=%h count=%0d",
                   got.status, got.handle, got.prio, got.sender, got.count);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.cmd          = '0;
    req_if.msg_handle   = '0;
    req_if.msg_priority = '0;
    req_if.sender_id    = '0;
    req_if.pick_rank    = '0;
    mbox_count          = 0;
    error_count         = 0;
    idle_enable         = 1'b1;
    hold_request        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_commands();
    test_ordering();
    test_full_store();
    test_receiver_hold();
    test_random_mix(560);
    test_steady_tail(100);

    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    // Catch any stray response after the last one.
    repeat (Depth + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
